// ===== src/u2u_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies; imported by every module of the block.
package u2u_pkg;

    // Command queue between decoder and unit expander
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Code point limits and UTF-16 constants
    localparam logic [15:0] REPL_CHAR    = 16'hFFFD;
    localparam logic [20:0] MIN_TWO      = 21'h000080;
    localparam logic [20:0] MIN_THREE    = 21'h000800;
    localparam logic [20:0] SUPP_BASE    = 21'h010000;
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    localparam logic [20:0] SURR_FIRST   = 21'h00D800;
    localparam logic [20:0] SURR_LAST    = 21'h00DFFF;
    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

    // One decoded request: rep_cnt replacement units, then val_cnt real units
    typedef struct packed {
        logic [2:0]  rep_cnt;
        logic [1:0]  val_cnt;
        logic [15:0] unit0;
        logic [15:0] unit1;
    } u2u_cmd_t;

endpackage

// ===== src/u2u_front.sv =====
// Front end: accepts UTF-8 bytes, keeps the partial sequence, classifies each byte
// into one expansion command. Depends on u2u_pkg.
module u2u_front
    import u2u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_string,
    input  logic        q_full,
    output logic        q_push,
    output u2u_cmd_t    q_wr_data
);

    logic [1:0]  exp_reg, exp_next;
    logic [1:0]  held_reg, held_next;
    logic [20:0] acc_reg, acc_next;

    logic        accept;
    logic        pending;
    logic        is_cont;
    logic [2:0]  flush_cnt;
    logic [20:0] acc_shift;
    logic [20:0] cp_min;
    logic        cp_bad;
    logic [20:0] supp_off;
    logic [2:0]  cmd_total;
    u2u_cmd_t    cmd;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = q_full;
    assign pending   = (exp_reg != 2'd0);
    assign is_cont   = (data_byte[7:6] == 2'b10);
    assign flush_cnt = pending ? {1'b0, held_reg} : 3'd0;
    assign acc_shift = {acc_reg[14:0], data_byte[5:0]};
    assign supp_off  = acc_shift - SUPP_BASE;

    // Smallest code point allowed for the pending sequence length
    always_comb
    begin
        case (exp_reg)
            2'd1:    cp_min = MIN_TWO;
            2'd2:    cp_min = MIN_THREE;
            2'd3:    cp_min = SUPP_BASE;
            default: cp_min = MIN_TWO;
        endcase
    end

    // Reject overlong, above-range and surrogate values
    assign cp_bad = (acc_shift < cp_min) || (acc_shift > CP_MAX) ||
                    ((acc_shift >= SURR_FIRST) && (acc_shift <= SURR_LAST));

    // Classify the byte and compute the next sequence state
    always_comb
    begin
        cmd       = '0;
        exp_next  = exp_reg;
        held_next = held_reg;
        acc_next  = acc_reg;
        if (data_byte == 8'h00)
        begin
            // Zero byte: flush what is held, emit nothing for itself
            cmd.rep_cnt = flush_cnt;
            exp_next    = 2'd0;
            held_next   = 2'd0;
            acc_next    = '0;
        end
        else if (pending && is_cont)
        begin
            acc_next = acc_shift;
            if (held_reg == exp_reg)
            begin
                exp_next  = 2'd0;
                held_next = 2'd0;
                acc_next  = '0;
                if (cp_bad)
                begin
                    cmd.rep_cnt = {1'b0, exp_reg} + 3'd1;
                end
                else if (acc_shift > 21'h00FFFF)
                begin
                    cmd.val_cnt = 2'd2;
                    cmd.unit0   = HI_SURR_BASE + {6'b0, supp_off[19:10]};
                    cmd.unit1   = LO_SURR_BASE + {6'b0, supp_off[9:0]};
                end
                else
                begin
                    cmd.val_cnt = 2'd1;
                    cmd.unit0   = acc_shift[15:0];
                end
            end
            else
            begin
                held_next = held_reg + 2'd1;
                if (end_of_string)
                begin
                    cmd.rep_cnt = {1'b0, held_reg} + 3'd1;
                    exp_next    = 2'd0;
                    held_next   = 2'd0;
                    acc_next    = '0;
                end
            end
        end
        else
        begin
            // Drop any broken sequence, then decode the byte fresh
            cmd.rep_cnt = flush_cnt;
            exp_next    = 2'd0;
            held_next   = 2'd0;
            acc_next    = '0;
            if (!data_byte[7])
            begin
                cmd.val_cnt = 2'd1;
                cmd.unit0   = {8'h00, data_byte};
            end
            else if ((data_byte[7:5] == 3'b110) || (data_byte[7:4] == 4'b1110) ||
                     (data_byte[7:3] == 5'b11110))
            begin
                if (end_of_string)
                begin
                    cmd.rep_cnt = flush_cnt + 3'd1;
                end
                else
                begin
                    held_next = 2'd1;
                    if (data_byte[7:5] == 3'b110)
                    begin
                        exp_next = 2'd1;
                        acc_next = {16'b0, data_byte[4:0]};
                    end
                    else if (data_byte[7:4] == 4'b1110)
                    begin
                        exp_next = 2'd2;
                        acc_next = {17'b0, data_byte[3:0]};
                    end
                    else
                    begin
                        exp_next = 2'd3;
                        acc_next = {18'b0, data_byte[2:0]};
                    end
                end
            end
            else
            begin
                cmd.rep_cnt = flush_cnt + 3'd1;
            end
        end
    end

    assign cmd_total = cmd.rep_cnt + {1'b0, cmd.val_cnt};
    assign q_push    = accept && (cmd_total != 3'd0);
    assign q_wr_data = cmd;

    // Hold sequence state between requests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg  <= 2'd0;
            held_reg <= 2'd0;
            acc_reg  <= '0;
        end
        else if (accept)
        begin
            exp_reg  <= exp_next;
            held_reg <= held_next;
            acc_reg  <= acc_next;
        end
    end

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (exp_reg == 2'd0) |-> (held_reg == 2'd0) && (acc_reg == '0))
        else $error("idle decoder holds stale sequence state");

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        (exp_reg != 2'd0) |-> (held_reg != 2'd0) && (held_reg <= exp_reg))
        else $error("held byte count outside expected length");

    a_cmd_size: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (cmd_total != 3'd0) && (cmd_total <= 3'd4))
        else $error("command expands to an illegal unit count");

endmodule

// ===== src/u2u_queue.sv =====
// Short command queue between the decoder and the unit expander.
// Depends on u2u_pkg for depth and the command type.
module u2u_queue
    import u2u_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  u2u_cmd_t wr_data,
    output logic     full,
    input  logic     pop,
    output u2u_cmd_t rd_data,
    output logic     empty
);

    u2u_cmd_t        entry_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_CW-1:0] count_reg;

    assign full    = (count_reg == Q_CW'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + Q_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + Q_AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + Q_CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - Q_CW'(1);
            end
        end
    end

endmodule

// ===== src/u2u_back.sv =====
// Back end: expands the head command into UTF-16 units, one per cycle
// while the output is not stalled, into a registered output. Depends on u2u_pkg.
module u2u_back
    import u2u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  u2u_cmd_t    q_rd_data,
    input  logic        q_empty,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] code_unit,
    output logic        replaced,
    output logic        run_last
);

    logic [2:0]  idx_reg;
    logic        out_valid_reg;
    logic [15:0] code_unit_reg;
    logic        replaced_reg;
    logic        run_last_reg;

    logic [2:0]  total;
    logic        load;
    logic        last;
    logic [15:0] unit_sel;
    logic        rep_sel;

    assign total = q_rd_data.rep_cnt + {1'b0, q_rd_data.val_cnt};
    assign last  = (idx_reg == total - 3'd1);
    assign load  = !q_empty && (!out_valid_reg || !out_stall);
    assign q_pop = load && last;

    // Pick the unit at the current position of the command
    always_comb
    begin
        if (idx_reg < q_rd_data.rep_cnt)
        begin
            unit_sel = REPL_CHAR;
            rep_sel  = 1'b1;
        end
        else if (idx_reg == q_rd_data.rep_cnt)
        begin
            unit_sel = q_rd_data.unit0;
            rep_sel  = 1'b0;
        end
        else
        begin
            unit_sel = q_rd_data.unit1;
            rep_sel  = 1'b0;
        end
    end

    // Advance the position and the output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                idx_reg       <= last ? 3'd0 : idx_reg + 3'd1;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            code_unit_reg <= unit_sel;
            replaced_reg  <= rep_sel;
            run_last_reg  <= last;
        end
    end

    assign out_valid = out_valid_reg;
    assign code_unit = code_unit_reg;
    assign replaced  = replaced_reg;
    assign run_last  = run_last_reg;

    a_idx_in_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> (idx_reg < total))
        else $error("expander position past end of command");

    a_pop_restart: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (idx_reg == 3'd0))
        else $error("expander did not restart after finishing a command");

endmodule

// ===== src/utf8_to_utf16_transcoder.sv =====
// Top level of the UTF-8 to UTF-16 transcoder.
// Instantiates u2u_front, u2u_queue and u2u_back; depends on u2u_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one UTF-8 byte per request,
//   with end_of_string marking the last byte of a string. Output channel
//   (out_valid / out_stall) carries one UTF-16 code unit per request, with
//   replaced set on U+FFFD substitutes and run_last on the last unit caused
//   by an input byte. A byte that causes no unit produces nothing.
//   The first unit of a byte passes through the command queue and then the
//   output register before it appears.
//   Throughput: one byte per cycle while each byte yields at most one unit
//   and the output is not stalled; the expander emits one unit per cycle.
//   A four-entry command queue absorbs the bursts of multi-unit bytes.
//   When the output is stalled the unit is held and the queue fills; once it
//   is full, in_stall rises until the expander frees an entry.
//   Reset clears the pending sequence, the queue and the output valid.
module utf8_to_utf16_transcoder
    import u2u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_string,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] code_unit,
    output logic        replaced,
    output logic        run_last
);

    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_empty;
    u2u_cmd_t q_wr_data;
    u2u_cmd_t q_rd_data;

    u2u_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_string (end_of_string),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_wr_data     (q_wr_data)
    );

    u2u_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    u2u_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_rd_data (q_rd_data),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .code_unit (code_unit),
        .replaced  (replaced),
        .run_last  (run_last)
    );

endmodule
